// ----- sv/vnu_pkg.sv -----
// ----------------------------------------------------------------------------
// vnu_pkg
// Shared constants and types for the vector normalize unit.
// ----------------------------------------------------------------------------
package vnu_pkg;

    // supported dimension range
    localparam logic [2:0] DIMS_MIN = 3'd2;
    localparam logic [2:0] DIMS_MAX = 3'd4;

    // number of vector lanes
    localparam int NUM_LANES = 4;

endpackage

// ----- sv/vector_normalize_unit.sv -----
// ----------------------------------------------------------------------------
// vector_normalize_unit
// Pipelined vector magnitude and unit-vector computation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries dims and four signed components per transaction.
//   The output channel carries the magnitude, four Q1.FRAC_BITS unit components
//   and a zero-vector flag. Both channels use valid and stall; a transaction
//   moves on a rising edge with valid high and stall low.
//   One transaction is accepted every cycle while the output is not stalled.
//   The pipeline has three stages for abs, squares and sum, COMP_WIDTH+1
//   square-root steps (one bit per stage) and FRAC_BITS+2 restoring divide
//   steps per lane. The square-root and divider stages set the latency.
//   Unused components give zero unit fields. dims 0 and 1 act as 2, and 5 to
//   7 act as 4.
//   A stall on the output freezes the whole pipeline and holds every stage,
//   so nothing is lost or repeated; i_stall is passed back as o_stall.
//   Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module vector_normalize_unit #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_dims,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    input  logic signed [COMP_WIDTH-1:0] i_comp_z,
    input  logic signed [COMP_WIDTH-1:0] i_comp_w,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [COMP_WIDTH:0]          o_magnitude,
    output logic signed [FRAC_BITS+1:0]  o_unit_x,
    output logic signed [FRAC_BITS+1:0]  o_unit_y,
    output logic signed [FRAC_BITS+1:0]  o_unit_z,
    output logic signed [FRAC_BITS+1:0]  o_unit_w,
    output logic                         o_zero_vector
);
    import vnu_pkg::*;

    localparam int CW    = COMP_WIDTH;
    localparam int AW    = CW;             // abs value width (holds 2^(CW-1))
    localparam int SQW   = 2 * AW;         // square width
    localparam int SUMW  = SQW + 2;        // sum of four squares
    localparam int RW    = CW + 1;         // root width
    localparam int NSQ   = SUMW / 2;       // root steps, one bit per stage
    localparam int QW    = FRAC_BITS + 2;  // quotient width
    localparam int DW    = AW + FRAC_BITS; // dividend width
    localparam int NST   = 3 + NSQ + QW;   // total stages
    localparam logic [QW-1:0] UNIT_ONE = QW'(1) << FRAC_BITS;

    // global advance enable: a stalled output freezes every stage
    logic w_adv;
    assign w_adv   = !i_stall;
    assign o_stall = i_stall;

    // valid bits, one per stage
    logic [NST-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 0: clamp dims, absolute values, lane enables
    logic [AW-1:0]        r_abs0 [NUM_LANES];
    logic [NUM_LANES-1:0] r_neg0;
    logic [NUM_LANES-1:0] r_use0;
    logic [CW-1:0]        w_in [NUM_LANES];
    assign w_in[0] = i_comp_x;
    assign w_in[1] = i_comp_y;
    assign w_in[2] = i_comp_z;
    assign w_in[3] = i_comp_w;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_neg0[i] <= w_in[i][CW-1];
                r_abs0[i] <= w_in[i][CW-1] ? (~w_in[i] + AW'(1)) : w_in[i];
            end
            r_use0[0] <= 1'b1;
            r_use0[1] <= 1'b1;
            r_use0[2] <= (i_dims >= 3'd3);
            r_use0[3] <= (i_dims >= DIMS_MAX);
        end
    end

    // stage 1: squares of used lanes
    logic [SQW-1:0]       r_sq1  [NUM_LANES];
    logic [AW-1:0]        r_abs1 [NUM_LANES];
    logic [NUM_LANES-1:0] r_neg1;
    logic [NUM_LANES-1:0] r_use1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_sq1[i]  <= r_use0[i] ? (SQW'(r_abs0[i]) * SQW'(r_abs0[i])) : '0;
                r_abs1[i] <= r_use0[i] ? r_abs0[i] : '0;
            end
            r_neg1 <= r_neg0;
            r_use1 <= r_use0;
        end
    end

    // square-root pipeline registers, entry 0 is the sum stage
    logic [SUMW-1:0]      r_srem [NSQ+1];
    logic [RW-1:0]        r_root [NSQ+1];
    logic [AW-1:0]        r_sabs [NSQ+1][NUM_LANES];
    logic [NUM_LANES-1:0] r_sneg [NSQ+1];

    // stage 2: sum of squares
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_srem[0] <= SUMW'(r_sq1[0]) + SUMW'(r_sq1[1])
                       + SUMW'(r_sq1[2]) + SUMW'(r_sq1[3]);
            r_root[0] <= '0;
            r_sabs[0] <= r_abs1;
            r_sneg[0] <= r_neg1;
        end
    end

    // square-root pipeline: one root bit per stage, restoring method
    for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
        localparam int SH = 2 * (NSQ - 1 - s);
        logic [SUMW+1:0] w_trial;
        logic [SUMW+1:0] w_rem;
        assign w_rem   = (SUMW+2)'(r_srem[s]);
        assign w_trial = (((SUMW+2)'(r_root[s]) << 2) | (SUMW+2)'(1)) << SH;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_rem >= w_trial) begin
                    r_srem[s+1] <= SUMW'(w_rem - w_trial);
                    r_root[s+1] <= RW'({r_root[s], 1'b1});
                end else begin
                    r_srem[s+1] <= r_srem[s];
                    r_root[s+1] <= RW'({r_root[s], 1'b0});
                end
                r_sabs[s+1] <= r_sabs[s];
                r_sneg[s+1] <= r_sneg[s];
            end
        end
    end

    // divider pipeline: one quotient bit per stage per lane
    logic [RW-1:0]        r_dmag [1:QW];
    logic [DW:0]          r_drem [1:QW][NUM_LANES];
    logic [DW-1:0]        r_dnum [1:QW][NUM_LANES];
    logic [QW-1:0]        r_quo  [1:QW][NUM_LANES];
    logic [NUM_LANES-1:0] r_dneg [1:QW];

    // only the low QW quotient bits can be set (quotient <= 2^FRAC_BITS),
    // so the upper dividend bits are preloaded into the partial remainder
    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [RW-1:0]        w_dmag;
        logic [NUM_LANES-1:0] w_dneg;
        // first stage takes the root and lane data from the square root
        if (d == 0) begin : g_head
            assign w_dmag = r_root[NSQ];
            assign w_dneg = r_sneg[NSQ];
        end else begin : g_body
            assign w_dmag = r_dmag[d];
            assign w_dneg = r_dneg[d];
        end
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            logic [DW-1:0] w_dnum;
            logic [QW-1:0] w_quo;
            logic [DW+1:0] w_pr;
            logic [DW+1:0] w_try;
            if (d == 0) begin : g_head
                assign w_dnum = DW'(r_sabs[NSQ][l]) << FRAC_BITS;
                assign w_quo  = '0;
                assign w_pr   = (DW+2)'(w_dnum >> (QW - 1));
            end else begin : g_body
                assign w_dnum = r_dnum[d][l];
                assign w_quo  = r_quo[d][l];
                assign w_pr   = {r_drem[d][l], w_dnum[QW-1-d]};
            end
            assign w_try = w_pr - (DW+2)'(w_dmag);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (!w_try[DW+1]) begin
                        r_drem[d+1][l] <= (DW+1)'(w_try);
                        r_quo[d+1][l]  <= {w_quo[QW-2:0], 1'b1};
                    end else begin
                        r_drem[d+1][l] <= (DW+1)'(w_pr);
                        r_quo[d+1][l]  <= {w_quo[QW-2:0], 1'b0};
                    end
                    r_dnum[d+1][l] <= w_dnum;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dmag[d+1] <= w_dmag;
                r_dneg[d+1] <= w_dneg;
            end
        end
    end

    // output: zero guard, saturation and sign
    logic [QW-1:0] w_sat [NUM_LANES];
    logic [QW-1:0] w_unit [NUM_LANES];
    logic          w_zero;
    always_comb begin
        w_zero = (r_dmag[QW] == '0);
        for (int i = 0; i < NUM_LANES; i++) begin
            w_sat[i]  = (r_quo[QW][i] > UNIT_ONE) ? UNIT_ONE : r_quo[QW][i];
            w_unit[i] = w_zero ? '0 : (r_dneg[QW][i] ? (~w_sat[i] + QW'(1)) : w_sat[i]);
        end
    end

    assign o_valid       = r_vld[NST-1];
    assign o_magnitude   = r_dmag[QW];
    assign o_unit_x      = w_unit[0];
    assign o_unit_y      = w_unit[1];
    assign o_unit_z      = w_unit[2];
    assign o_unit_w      = w_unit[3];
    assign o_zero_vector = w_zero;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case vectors into the vector normalize unit and
// checks magnitude, unit components and zero flag against a local predictor.
// ----------------------------------------------------------------------------

// expected result of one vector transaction
typedef struct {
    logic [16:0]        mag;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] uw;
    logic               zflag;
} t_norm_result;

class norm_scoreboard;
    t_norm_result pending[$];
    int           errors;

    // integer square root, bit by bit
    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem = x;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // work out the normalized vector for one accepted transaction
    function void note_vector(logic [2:0] dims, logic signed [15:0] cx,
                              logic signed [15:0] cy, logic signed [15:0] cz,
                              logic signed [15:0] cw);
        longint unsigned absv[4];
        logic            negv[4];
        logic signed [15:0] comps[4];
        logic signed [15:0] units[4];
        longint unsigned sum;
        longint unsigned mag;
        longint unsigned q;
        int              n;
        t_norm_result    r;
        comps[0] = cx; comps[1] = cy; comps[2] = cz; comps[3] = cw;
        n = (dims < vnu_pkg::DIMS_MIN) ? 2 : (dims > vnu_pkg::DIMS_MAX) ? 4 : int'(dims);
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            negv[i] = comps[i][15];
            absv[i] = negv[i] ? longint'(-int'(comps[i])) : longint'(comps[i]);
            units[i] = 0;
        end
        for (int i = 0; i < n; i++) sum += absv[i] * absv[i];
        mag = isqrt(sum);
        if (mag != 0) begin
            for (int i = 0; i < n; i++) begin
                q = (absv[i] << 14) / mag;
                if (q > 16384) q = 16384;
                units[i] = negv[i] ? -16'(q) : 16'(q);
            end
        end
        r.mag = mag[16:0];
        r.ux = units[0]; r.uy = units[1]; r.uz = units[2]; r.uw = units[3];
        r.zflag = (mag == 0);
        pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // compare one output transaction with the oldest expectation
    task check_result(t_norm_result got);
        t_norm_result want;
        if (pending.size() == 0) begin
            $display("unexpected output transaction");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.mag !== want.mag) report("magnitude", got.mag, want.mag);
        if (got.ux !== want.ux) report("unit_x", got.ux, want.ux);
        if (got.uy !== want.uy) report("unit_y", got.uy, want.uy);
        if (got.uz !== want.uz) report("unit_z", got.uz, want.uz);
        if (got.uw !== want.uw) report("unit_w", got.uw, want.uw);
        if (got.zflag !== want.zflag) report("zero_vector", got.zflag, want.zflag);
    endtask
endclass

module testbench;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_dims;
    logic signed [15:0] i_comp_x, i_comp_y, i_comp_z, i_comp_w;
    logic               o_valid;
    logic               i_stall;
    logic [16:0]        o_magnitude;
    logic signed [15:0] o_unit_x, o_unit_y, o_unit_z, o_unit_w;
    logic               o_zero_vector;

    norm_scoreboard sb;
    int unsigned    cycle_count;
    int             stall_mode;
    logic           sink_quiet;

    vector_normalize_unit uut (.*);

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sample outputs at the rising edge
    always @(posedge i_clk) begin
        t_norm_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.mag = o_magnitude;
            got.ux = o_unit_x; got.uy = o_unit_y;
            got.uz = o_unit_z; got.uw = o_unit_w;
            got.zflag = o_zero_vector;
            sb.check_result(got);
        end
    end

    // receiver stall pattern, mode changes now and then
    always @(negedge i_clk) begin
        if (sink_quiet) begin
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // present one transaction and hold it until accepted
    task automatic send_vector(logic [2:0] d, logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, logic signed [15:0] w);
        i_valid <= 1'b1;
        i_dims <= d;
        i_comp_x <= x; i_comp_y <= y; i_comp_z <= z; i_comp_w <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_vector(d, x, y, z, w);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // pick a component: extremes, small values or full range
    function automatic logic signed [15:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0] d;
        int         burst;
        sb = new();
        cycle_count = 0;
        stall_mode = 0;
        sink_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_dims = 3'd2;
        i_comp_x = 0; i_comp_y = 0; i_comp_z = 0; i_comp_w = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners: zero vector, extremes, unused lanes, odd dims
        send_vector(3'd2, 0, 0, 16'sh7fff, 16'sh8000);
        send_vector(3'd4, 0, 0, 0, 0);
        send_vector(3'd3, 0, 0, 0, 5);
        send_vector(3'd2, 16'sh8000, 0, 0, 0);
        send_vector(3'd2, 16'sh7fff, 0, 0, 0);
        send_vector(3'd4, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(3'd4, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(3'd3, 16'sh8000, 16'sh7fff, 16'sh8000, 123);
        send_vector(3'd2, 3, 4, 99, 99);
        send_vector(3'd3, -1, -1, -1, 7);
        send_vector(3'd4, 1, 0, 0, 0);
        send_vector(3'd0, 3, -4, 100, 100);
        send_vector(3'd1, -5, 12, 1, 1);
        send_vector(3'd5, 1, 2, 2, 4);
        send_vector(3'd6, -1, 1, -1, 1);
        send_vector(3'd7, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001);
        send_vector(3'd4, 0, 0, 0, 16'sh8000);
        send_vector(3'd3, 0, 0, -1, 0);

        // hold off until the pipeline drains
        idle_cycles(1);
        while (sb.pending.size() != 0) @(negedge i_clk);

        // random bursts with gaps
        for (int n = 0; n < 1400; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                d = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
                send_vector(d, pick_comp(), pick_comp(), pick_comp(), pick_comp());
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
        end

        // drain
        idle_cycles(1);
        sink_quiet = 1'b1;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
